// ===== hdl/fpn_pkg.sv =====
// ----------------------------------------------------------------------------
// Fractal Perlin noise package
// Shared widths, register indexes, the permutation table and the small
// arithmetic helpers of the noise core.
// ----------------------------------------------------------------------------
package fpn_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 12;

    localparam int COORD_W    = 32;
    localparam int OCT_W      = 4;
    localparam int LAC_W      = 8 + FRAC_BITS;
    localparam int GAIN_W     = FRAC_BITS + 1;
    localparam int FREQ_W     = 8 + 2 * FRAC_BITS;
    localparam int AMP_W      = FRAC_BITS + 1;
    localparam int TOT_W      = FRAC_BITS + 4;
    localparam int FADE_W     = FRAC_BITS + 1;
    localparam int FB_W       = FRAC_BITS + 4;
    localparam int POS_W      = FRAC_BITS + 2;
    localparam int NOISE_W    = FRAC_BITS + 4;
    localparam int PROD_W     = NOISE_W + AMP_W + 1;
    localparam int ACC_W      = PROD_W + 4;
    localparam int NUM_W      = ACC_W - 1;
    localparam int QUO_W      = FRAC_BITS + 2;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd2;

    localparam logic [AMP_W-1:0]  ONE_AMP  = AMP_W'(1) << FRAC_BITS;
    localparam logic [FREQ_W-1:0] ONE_FREQ = FREQ_W'(1) << FRAC_BITS;
    localparam logic [OCT_W-1:0]  OCT_MAX  = OCT_W'(MAX_OCTAVES);
    localparam logic [LAC_W-1:0]  LAC_RESET  = LAC_W'(2) << FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [AMP_W-1:0] amp;
        logic [TOT_W-1:0] total;
        logic             first;
        logic             last;
    } t_oct_ctl;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic signed [NOISE_W-1:0] grad_dot(
        input logic [3:0]              h,
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] y,
        input logic signed [POS_W-1:0] z
    );
        logic signed [NOISE_W-1:0] u;
        logic signed [NOISE_W-1:0] v;
        u = (h < 4'd8) ? NOISE_W'(x) : NOISE_W'(y);
        if (h < 4'd4) begin
            v = NOISE_W'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = NOISE_W'(x);
        end else begin
            v = NOISE_W'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [NOISE_W-1:0] lerp(
        input logic signed [NOISE_W-1:0] a,
        input logic signed [NOISE_W-1:0] b,
        input logic [FADE_W-1:0]         w
    );
        logic signed [NOISE_W:0]          diff;
        logic signed [NOISE_W+FADE_W+1:0] prod;
        diff = (NOISE_W + 1)'(b) - (NOISE_W + 1)'(a);
        prod = diff * $signed({1'b0, w});
        return a + NOISE_W'(prod >>> FRAC_BITS);
    endfunction

endpackage

// ===== hdl/fpn_core.sv =====
// ----------------------------------------------------------------------------
// Fractal Perlin noise single-octave core
// Ten-stage pipeline: scales a point by the octave frequency, hashes the
// lattice corners, fades and mixes, and weights the noise by the amplitude.
// ----------------------------------------------------------------------------
module fpn_core
    import fpn_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  t_oct_ctl                       i_ctl,
    input  logic [2:0][COORD_W-1:0]        i_coord,
    input  logic [FREQ_W-1:0]              i_freq,
    output logic                           o_valid,
    output t_oct_ctl                       o_ctl,
    output logic signed [PROD_W-1:0]       o_weighted
);

    localparam int NSTG = 10;
    localparam int SX_W = 8 + 2 * FRAC_BITS;
    localparam logic [FB_W-1:0] FIFTEEN = FB_W'(15) << FRAC_BITS;
    localparam logic [FB_W-1:0] TEN     = FB_W'(10) << FRAC_BITS;
    localparam logic signed [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;

    logic [NSTG-1:0] r_v;
    t_oct_ctl        r_ctl [NSTG];

    logic [SX_W-1:0]      r1_lo [3];
    logic [7:0]           r1_hi [3];
    logic [7:0]           r2_cell [3];
    logic [FRAC_BITS-1:0] r2_t [3];
    logic [7:0]           r3_pa, r3_pb, r3_cy, r3_cz;
    logic [FRAC_BITS-1:0] r3_t [3];
    logic [FB_W-1:0]      r3_f [3];
    logic [7:0]           r4_h [4];
    logic [FRAC_BITS-1:0] r4_t [3];
    logic [FB_W-1:0]      r4_f [3];
    logic [3:0]           r5_g [8];
    logic [FRAC_BITS-1:0] r5_t [3];
    logic [FB_W-1:0]      r5_f [3];
    logic signed [NOISE_W-1:0] r6_d [8];
    logic [FADE_W-1:0]    r6_u [3];
    logic signed [NOISE_W-1:0] r7_m [4];
    logic [FADE_W-1:0]    r7_v, r7_w;
    logic signed [NOISE_W-1:0] r8_n [2];
    logic [FADE_W-1:0]    r8_w;
    logic signed [NOISE_W-1:0] r9_n;
    logic signed [PROD_W-1:0]  r10_p;

    logic signed [COORD_W+FREQ_W-8:0] w_plo [3];
    logic [15:0]                      w_phi [3];
    logic [SX_W-1:0]                  w_s [3];
    logic [FB_W+FRAC_BITS-1:0]        w_fm [3];
    logic [FB_W+FRAC_BITS-1:0]        w_c1 [3];
    logic [FB_W+FRAC_BITS-1:0]        w_c2 [3];
    logic [FB_W+FRAC_BITS-1:0]        w_c3 [3];
    logic [7:0]                       w_a, w_b;
    logic signed [POS_W-1:0]          w_px [8];
    logic signed [POS_W-1:0]          w_py [8];
    logic signed [POS_W-1:0]          w_pz [8];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_plo[l] = $signed(i_coord[l]) * $signed({1'b0, i_freq[31:0]});
            w_phi[l] = i_coord[l][7:0] * i_freq[FREQ_W-1:32];
            w_s[l]   = r1_lo[l] + {r1_hi[l], 32'b0};
            w_fm[l]  = r2_t[l] * (FIFTEEN - FB_W'(6 * r2_t[l]));
            w_c1[l]  = r3_t[l] * r3_f[l];
            w_c2[l]  = r4_t[l] * r4_f[l];
            w_c3[l]  = r5_t[l] * r5_f[l];
        end
        for (int j = 0; j < 8; j++) begin
            w_px[j] = $signed({2'b0, r5_t[0]}) - ((j % 2 == 1) ? ONE_POS : '0);
            w_py[j] = $signed({2'b0, r5_t[1]}) - (((j / 2) % 2 == 1) ? ONE_POS : '0);
            w_pz[j] = $signed({2'b0, r5_t[2]}) - ((j / 4 == 1) ? ONE_POS : '0);
        end
        w_a = r3_pa + r3_cy;
        w_b = r3_pb + r3_cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[0] <= i_ctl;
        for (int s = 1; s < NSTG; s++) begin
            r_ctl[s] <= r_ctl[s-1];
        end
        for (int l = 0; l < 3; l++) begin
            r1_lo[l]   <= w_plo[l][SX_W-1:0];
            r1_hi[l]   <= w_phi[l][7:0];
            r2_cell[l] <= w_s[l][SX_W-1:SX_W-8];
            r2_t[l]    <= w_s[l][2*FRAC_BITS-1:FRAC_BITS];
            r3_t[l]    <= r2_t[l];
            r3_f[l]    <= TEN - w_fm[l][FB_W+FRAC_BITS-1:FRAC_BITS];
            r4_t[l]    <= r3_t[l];
            r4_f[l]    <= w_c1[l][FB_W+FRAC_BITS-1:FRAC_BITS];
            r5_t[l]    <= r4_t[l];
            r5_f[l]    <= w_c2[l][FB_W+FRAC_BITS-1:FRAC_BITS];
            r6_u[l]    <= w_c3[l][FRAC_BITS+FADE_W-1:FRAC_BITS];
        end
        r3_pa <= PERM_ROM[r2_cell[0]];
        r3_pb <= PERM_ROM[r2_cell[0] + 8'd1];
        r3_cy <= r2_cell[1];
        r3_cz <= r2_cell[2];
        r4_h[0] <= PERM_ROM[w_a] + r3_cz;
        r4_h[1] <= PERM_ROM[w_b] + r3_cz;
        r4_h[2] <= PERM_ROM[w_a + 8'd1] + r3_cz;
        r4_h[3] <= PERM_ROM[w_b + 8'd1] + r3_cz;
        for (int j = 0; j < 4; j++) begin
            r5_g[j]     <= PERM_ROM[r4_h[j]][3:0];
            r5_g[j + 4] <= PERM_ROM[r4_h[j] + 8'd1][3:0];
        end
        for (int j = 0; j < 8; j++) begin
            r6_d[j] <= grad_dot(r5_g[j], w_px[j], w_py[j], w_pz[j]);
        end
        for (int k = 0; k < 4; k++) begin
            r7_m[k] <= lerp(r6_d[2*k], r6_d[2*k+1], r6_u[0]);
        end
        r7_v    <= r6_u[1];
        r7_w    <= r6_u[2];
        r8_n[0] <= lerp(r7_m[0], r7_m[1], r7_v);
        r8_n[1] <= lerp(r7_m[2], r7_m[3], r7_v);
        r8_w    <= r7_w;
        r9_n    <= lerp(r8_n[0], r8_n[1], r8_w);
        r10_p   <= PROD_W'(r9_n) * PROD_W'($signed({1'b0, r_ctl[8].amp}));
    end

    assign o_valid    = r_v[NSTG-1];
    assign o_ctl      = r_ctl[NSTG-1];
    assign o_weighted = r10_p;

endmodule

// ===== hdl/fpn_div.sv =====
// ----------------------------------------------------------------------------
// Fractal Perlin noise divider
// Pipelined restoring divider, one quotient bit per stage, for the
// normalisation of the weighted sum by the amplitude total.
// ----------------------------------------------------------------------------
module fpn_div
    import fpn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_neg,
    input  logic [NUM_W-1:0] i_num,
    input  logic [TOT_W-1:0] i_den,
    output logic             o_valid,
    output logic             o_neg,
    output logic [QUO_W-1:0] o_quo
);

    logic [QUO_W-1:0] r_v;
    logic             r_neg [QUO_W];
    logic [TOT_W-1:0] r_rem [QUO_W];
    logic [TOT_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    logic             s_neg [QUO_W];
    logic [TOT_W-1:0] s_rem [QUO_W];
    logic [TOT_W-1:0] s_den [QUO_W];
    logic [QUO_W-1:0] s_low [QUO_W];
    logic [QUO_W-1:0] s_quo [QUO_W];
    logic [TOT_W:0]   s_trial [QUO_W];
    logic             s_ge [QUO_W];

    always_comb begin
        s_neg[0] = i_neg;
        s_rem[0] = TOT_W'(i_num[NUM_W-1:QUO_W]);
        s_den[0] = i_den;
        s_low[0] = i_num[QUO_W-1:0];
        s_quo[0] = '0;
        for (int s = 1; s < QUO_W; s++) begin
            s_neg[s] = r_neg[s-1];
            s_rem[s] = r_rem[s-1];
            s_den[s] = r_den[s-1];
            s_low[s] = r_low[s-1];
            s_quo[s] = r_quo[s-1];
        end
        for (int s = 0; s < QUO_W; s++) begin
            s_trial[s] = {s_rem[s], s_low[s][QUO_W-1]};
            s_ge[s]    = s_trial[s] >= {1'b0, s_den[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QUO_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QUO_W; s++) begin
            r_neg[s] <= s_neg[s];
            r_den[s] <= s_den[s];
            r_low[s] <= {s_low[s][QUO_W-2:0], 1'b0};
            r_quo[s] <= {s_quo[s][QUO_W-2:0], s_ge[s]};
            r_rem[s] <= s_ge[s] ? TOT_W'(s_trial[s] - {1'b0, s_den[s]})
                                : TOT_W'(s_trial[s]);
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_neg   = r_neg[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

endmodule

// ===== hdl/fractal_perlin_noise_3d.sv =====
// ----------------------------------------------------------------------------
// Fractal Perlin noise, three dimensions
// Fractal sum of improved Perlin noise octaves at one point, normalised by
// the amplitude total and saturated to plus or minus one.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; the point is
// taken from i_coord_x, i_coord_y and i_coord_z (signed Q16.16).
// After acceptance busy stays high while one octave per cycle is issued into
// the shared ten-stage noise core, until the last octave has been issued; the
// next point is accepted only once busy is low again, so a new point cannot be
// taken before all octaves of the last one are issued.
// The result appears on o_noise_value (signed Q2.16) for one cycle with
// o_strobe high, once the remaining octaves are issued and the last has passed
// the ten core stages, the accumulator, the eighteen-stage divider and the
// output register.
// The receiver cannot stall; results leave in acceptance order.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_wdata; the user
// must do so while the block is idle; the block does not enforce it. Synchronous
// reset empties the pipeline and restores one octave, lacunarity 2.0, gain 0.5.
// ----------------------------------------------------------------------------
module fractal_perlin_noise_3d
    import fpn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                      o_strobe,
    output logic signed [OUT_W-1:0]   o_noise_value
);

    localparam logic [QUO_W-1:0] QUO_ONE = QUO_W'(1) << FRAC_BITS;

    logic [OCT_W-1:0]  r_oct;
    logic [LAC_W-1:0]  r_lac;
    logic [GAIN_W-1:0] r_gain;

    logic                    r_busy;
    logic [OCT_W-1:0]        r_k;
    logic [2:0][COORD_W-1:0] r_coord;
    logic [FREQ_W-1:0]       r_freq;
    logic [AMP_W-1:0]        r_amp;
    logic [TOT_W-1:0]        r_tot;

    logic [ACC_W-1:0] r_acc;
    logic             r_dv;
    logic             r_dneg;
    logic [NUM_W-1:0] r_dnum;
    logic [TOT_W-1:0] r_dden;

    logic                  r_strobe;
    logic [OUT_W-1:0]      r_noise;

    logic [OCT_W-1:0]      n_cnt;
    logic [GAIN_W-1:0]     n_gain;
    logic [FREQ_W+LAC_W-1:0] n_fprod;
    logic [AMP_W+GAIN_W-1:0] n_aprod;
    t_oct_ctl              n_ctl;

    logic                     c_valid;
    t_oct_ctl                 c_ctl;
    logic signed [PROD_W-1:0] c_prod;
    logic [ACC_W-1:0]         n_sum;
    logic [ACC_W-1:0]         n_mag;

    logic             d_valid;
    logic             d_neg;
    logic [QUO_W-1:0] d_quo;
    logic [QUO_W-1:0] n_sat;

    always_comb begin
        if (r_oct == '0) begin
            n_cnt = OCT_W'(1);
        end else if (r_oct > OCT_MAX) begin
            n_cnt = OCT_MAX;
        end else begin
            n_cnt = r_oct;
        end
        n_gain      = (r_gain > GAIN_W'(ONE_AMP)) ? GAIN_W'(ONE_AMP) : r_gain;
        n_fprod     = r_freq * r_lac;
        n_aprod     = r_amp * n_gain;
        n_ctl.amp   = r_amp;
        n_ctl.total = r_tot + TOT_W'(r_amp);
        n_ctl.first = (r_k == '0);
        n_ctl.last  = (r_k == n_cnt - OCT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct  <= OCT_W'(1);
            r_lac  <= LAC_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OCTAVES: begin
                    r_oct <= i_cfg_wdata[OCT_W-1:0];
                end
                CFG_LACUNARITY: begin
                    r_lac <= i_cfg_wdata[LAC_W-1:0];
                end
                CFG_GAIN: begin
                    r_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (start && !r_busy) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (r_busy) begin
            r_k <= r_k + OCT_W'(1);
            if (n_ctl.last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_coord <= {i_coord_z, i_coord_y, i_coord_x};
            r_freq  <= ONE_FREQ;
            r_amp   <= ONE_AMP;
            r_tot   <= '0;
        end else if (r_busy) begin
            r_freq <= n_fprod[FREQ_W+FRAC_BITS-1:FRAC_BITS];
            r_amp  <= n_aprod[AMP_W+FRAC_BITS-1:FRAC_BITS];
            r_tot  <= n_ctl.total;
        end
    end

    fpn_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_busy),
        .i_ctl      (n_ctl),
        .i_coord    (r_coord),
        .i_freq     (r_freq),
        .o_valid    (c_valid),
        .o_ctl      (c_ctl),
        .o_weighted (c_prod)
    );

    always_comb begin
        n_sum = (c_ctl.first ? '0 : r_acc) + ACC_W'(c_prod);
        n_mag = n_sum[ACC_W-1] ? -n_sum : n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= c_valid && c_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_valid) begin
            r_acc <= n_sum;
        end
        r_dneg <= n_sum[ACC_W-1];
        r_dnum <= n_mag[NUM_W-1:0];
        r_dden <= c_ctl.total;
    end

    fpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv),
        .i_neg   (r_dneg),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_valid (d_valid),
        .o_neg   (d_neg),
        .o_quo   (d_quo)
    );

    assign n_sat = (d_quo > QUO_ONE) ? QUO_ONE : d_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_noise <= d_neg ? OUT_W'(-n_sat) : OUT_W'(n_sat);
    end

    assign busy          = r_busy;
    assign o_strobe      = r_strobe;
    assign o_noise_value = $signed(r_noise);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results delivered in adjacent cycles");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_noise_value <= 18'sd65536 && o_noise_value >= -18'sd65536))
        else $error("noise value outside the saturation range");

    a_divider_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_dden != '0 && r_dnum[NUM_W-1:QUO_W] < NUM_W'(r_dden)))
        else $error("divider quotient would overflow");

endmodule
